// ===== design/hcwr_pkg.sv =====
// Shared constants and types for the chained hash table block.
// No dependencies; imported by every other design file.
package hcwr_pkg;

   localparam int DEF_TABLE_SIZE = 16;
   localparam int DEF_KEY_BITS   = 16;

   localparam int KEY_PORT_W = 16;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 4;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

endpackage

// ===== design/hcwr_rem.sv =====
// Remainder unit: value modulo TABLE_SIZE by reciprocal multiplication.
// Depends on hcwr_pkg for parameter defaults.
module hcwr_rem #(
   parameter int TABLE_SIZE = hcwr_pkg::DEF_TABLE_SIZE,
   parameter int KEY_BITS   = hcwr_pkg::DEF_KEY_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KEY_BITS-1:0]           value,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] rem
);
   import hcwr_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int SHIFT  = KEY_BITS + IDX_W;
   localparam int RCP_W  = KEY_BITS + 1;
   localparam int PROD_W = KEY_BITS + RCP_W;
   localparam int MW     = KEY_BITS + IDX_W + 1;
   // ceil(2^SHIFT / TABLE_SIZE): quotient is exact for every KEY_BITS-bit value
   localparam logic [63:0] RCP_WIDE =
      ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
   localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_WIDE);

   logic                v1_ff, v1_in;
   logic                v2_ff, v2_in;
   logic                done_ff, done_in;
   logic [KEY_BITS-1:0] val_ff, val_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [IDX_W-1:0]    rem_ff, rem_in;
   logic [KEY_BITS-1:0] quo;

   assign quo = KEY_BITS'(prod_ff >> SHIFT);

   always_comb begin
      v1_in   = start;
      v2_in   = v1_ff;
      done_in = v2_ff;
      val_in  = val_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      if (start) begin
         val_in = value;
      end
      // stage 1: multiply by the reciprocal
      if (v1_ff) begin
         prod_in = PROD_W'(val_ff) * PROD_W'(RCP);
      end
      // stage 2: remainder = value - quotient * modulus
      if (v2_ff) begin
         rem_in = IDX_W'(MW'(val_ff) - MW'(quo) * MW'(TABLE_SIZE));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ===== design/hcwr_mem.sv =====
// Slot memory: one write port, one read port, registered read data.
// Depends on hcwr_pkg for parameter defaults.
module hcwr_mem #(
   parameter int TABLE_SIZE = hcwr_pkg::DEF_TABLE_SIZE,
   parameter int ENT_W      = 2 + $clog2(hcwr_pkg::DEF_TABLE_SIZE) + hcwr_pkg::DEF_KEY_BITS
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
   input  logic [ENT_W-1:0]              wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
   output logic [ENT_W-1:0]              rd_data
);
   import hcwr_pkg::*;

   logic [ENT_W-1:0] mem [TABLE_SIZE];
   logic [ENT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hash_table_chaining_with_replacement.sv =====
// Chained hash table with replacement: top level, sequencer and result register.
// Depends on hcwr_pkg, hcwr_rem and hcwr_mem.
//
// Use: each transfer on the req_ channel carries an operation (req_mode: 0 insert,
// 1 search) and a key. Exactly one transfer follows on the rsp_ channel with a
// status (inserted, table full, found, not found) and the slot concerned.
// Items are handled one at a time; req_stall is low only while the sequencer is
// idle. The home slot comes from a reciprocal-multiply remainder unit.
// Any item that finds its home occupied runs it a second time on the stored key.
// Chain walks and vacancy probes then read the slot memory one entry per cycle.
// The longest insert runs a chain walk plus a probe, or a probe plus a predecessor
// walk; the next request is taken in the cycle after the result loads.
// After reset a clearing pass zeroes every slot entry; req_stall stays high until
// it ends. The result sits in an output register,
// so a stalled receiver holds the sequencer only at the moment a second
// result is ready; an item can be accepted while the first one waits.
module hash_table_chaining_with_replacement #(
   parameter int TABLE_SIZE = hcwr_pkg::DEF_TABLE_SIZE,
   parameter int KEY_BITS   = hcwr_pkg::DEF_KEY_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [hcwr_pkg::KEY_PORT_W-1:0] req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hcwr_pkg::STATUS_W-1:0] rsp_status,
   output logic [hcwr_pkg::SLOT_W-1:0]   rsp_slot
);
   import hcwr_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int ENT_W = 2 + IDX_W + KEY_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   typedef struct packed {
      logic                valid;
      logic                lpres;   // link present
      logic [IDX_W-1:0]    link;
      logic [KEY_BITS-1:0] key;
   } entry_type;

   typedef enum logic [12:0] {
      S_CLEAR = 13'h0001,
      S_IDLE  = 13'h0002,
      S_HOME  = 13'h0004,
      S_READH = 13'h0008,
      S_HOMEK = 13'h0010,
      S_SCHK  = 13'h0020,
      S_CEND  = 13'h0040,
      S_PROBE = 13'h0080,
      S_PRED  = 13'h0100,
      S_WR1   = 13'h0200,
      S_WR2   = 13'h0400,
      S_WR3   = 13'h0800,
      S_DONE  = 13'h1000
   } state_type;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   // sequencer state
   state_type           state_ff, state_in;
   logic                mode_ff, mode_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [IDX_W-1:0]    h_ff, h_in;      // home of the new key
   logic [IDX_W-1:0]    hk_ff, hk_in;    // home of the key stored at h
   logic [IDX_W-1:0]    cur_ff, cur_in;  // walk / probe / clear position
   logic [IDX_W:0]      n_ff, n_in;      // step counter of the current walk
   logic [IDX_W-1:0]    e_ff, e_in;      // chain end
   logic [IDX_W-1:0]    v_ff, v_in;      // vacant slot found
   logic                havep_ff, havep_in;
   entry_type           eh_ff, eh_in;    // entry at home
   entry_type           ee_ff, ee_in;    // chain end or predecessor entry
   logic [IDX_W:0]      used_ff, used_in;
   status_type          res_st_ff, res_st_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_st_ff, rsp_st_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                load;

   // memory and remainder unit hookup
   logic                mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0]    mem_wr_addr, mem_rd_addr;
   entry_type           mem_wr_data, mem_rd_data;
   logic                rem_start, rem_done;
   logic [KEY_BITS-1:0] rem_val;
   logic [IDX_W-1:0]    rem_out;

   hcwr_rem #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_BITS   (KEY_BITS)
   ) u_rem (
      .clock (clock),
      .reset (reset),
      .start (rem_start),
      .value (rem_val),
      .done  (rem_done),
      .rem   (rem_out)
   );

   hcwr_mem #(
      .TABLE_SIZE (TABLE_SIZE),
      .ENT_W      (ENT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      key_in      = key_ff;
      h_in        = h_ff;
      hk_in       = hk_ff;
      cur_in      = cur_ff;
      n_in        = n_ff;
      e_in        = e_ff;
      v_in        = v_ff;
      havep_in    = havep_ff;
      eh_in       = eh_ff;
      ee_in       = ee_ff;
      used_in     = used_ff;
      res_st_in   = res_st_ff;
      res_slot_in = res_slot_ff;
      load        = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cur_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cur_ff;
      rem_start   = 1'b0;
      rem_val     = key_ff;

      case (state_ff)
         S_CLEAR: begin
            // zero one entry per cycle: no valid, no link
            mem_wr_en = 1'b1;
            cur_in    = wrap_inc(cur_ff);
            if (cur_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               key_in    = KEY_BITS'(req_key);
               rem_start = 1'b1;
               rem_val   = KEY_BITS'(req_key);
               state_in  = S_HOME;
            end
         end

         S_HOME: begin
            if (rem_done) begin
               h_in = rem_out;
               if (!mode_ff && used_ff == (IDX_W+1)'(TABLE_SIZE)) begin
                  // full: reported before touching anything
                  res_st_in   = ST_FULL;
                  res_slot_in = '0;
                  state_in    = S_DONE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = rem_out;
                  state_in    = S_READH;
               end
            end
         end

         S_READH: begin
            eh_in = mem_rd_data;
            if (!mem_rd_data.valid) begin
               if (!mode_ff) begin
                  mem_wr_en         = 1'b1;
                  mem_wr_addr       = h_ff;
                  mem_wr_data.valid = 1'b1;
                  mem_wr_data.key   = key_ff;
                  used_in           = used_ff + 1'b1;
                  res_st_in         = ST_INSERTED;
                  res_slot_in       = SLOT_W'(h_ff);
               end else begin
                  res_st_in   = ST_NOT_FOUND;
                  res_slot_in = '0;
               end
               state_in = S_DONE;
            end else begin
               rem_start = 1'b1;
               rem_val   = mem_rd_data.key;
               state_in  = S_HOMEK;
            end
         end

         S_HOMEK: begin
            // read data still holds the home entry here
            if (rem_done) begin
               hk_in = rem_out;
               n_in  = '0;
               if (mode_ff) begin
                  if (rem_out != h_ff) begin
                     res_st_in   = ST_NOT_FOUND;
                     res_slot_in = '0;
                     state_in    = S_DONE;
                  end else begin
                     cur_in   = h_ff;
                     state_in = S_SCHK;
                  end
               end else if (rem_out == h_ff) begin
                  cur_in   = h_ff;
                  state_in = S_CEND;
               end else begin
                  // displaced key at home: probe from the slot after home
                  cur_in      = wrap_inc(h_ff);
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = wrap_inc(h_ff);
                  state_in    = S_PROBE;
               end
            end
         end

         S_SCHK: begin
            if (mem_rd_data.valid && mem_rd_data.key == key_ff) begin
               res_st_in   = ST_FOUND;
               res_slot_in = SLOT_W'(cur_ff);
               state_in    = S_DONE;
            end else if (!mem_rd_data.lpres || n_ff == (IDX_W+1)'(TABLE_SIZE - 1)) begin
               res_st_in   = ST_NOT_FOUND;
               res_slot_in = '0;
               state_in    = S_DONE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mem_rd_data.link;
               cur_in      = mem_rd_data.link;
               n_in        = n_ff + 1'b1;
            end
         end

         S_CEND: begin
            if (mem_rd_data.lpres && n_ff != (IDX_W+1)'(TABLE_SIZE)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mem_rd_data.link;
               cur_in      = mem_rd_data.link;
               n_in        = n_ff + 1'b1;
            end else begin
               // chain end found; probe starts at the end slot itself
               e_in      = cur_ff;
               ee_in     = mem_rd_data;
               n_in      = '0;
               mem_rd_en = 1'b1;
               state_in  = S_PROBE;
            end
         end

         S_PROBE: begin
            if (!mem_rd_data.valid) begin
               v_in = cur_ff;
               if (hk_ff == h_ff) begin
                  state_in = S_WR1;
               end else begin
                  cur_in      = hk_ff;
                  n_in        = '0;
                  havep_in    = 1'b0;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = hk_ff;
                  state_in    = S_PRED;
               end
            end else if (n_ff == (IDX_W+1)'(TABLE_SIZE - 1)) begin
               res_st_in   = ST_FULL;
               res_slot_in = '0;
               state_in    = S_DONE;
            end else begin
               cur_in      = wrap_inc(cur_ff);
               n_in        = n_ff + 1'b1;
               mem_rd_en   = 1'b1;
               mem_rd_addr = wrap_inc(cur_ff);
            end
         end

         S_PRED: begin
            // look for the slot whose link points at home
            if (!mem_rd_data.lpres) begin
               state_in = S_WR1;
            end else if (mem_rd_data.link == h_ff) begin
               havep_in = 1'b1;
               ee_in    = mem_rd_data;
               state_in = S_WR1;
            end else if (n_ff == (IDX_W+1)'(TABLE_SIZE - 1)) begin
               state_in = S_WR1;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mem_rd_data.link;
               cur_in      = mem_rd_data.link;
               n_in        = n_ff + 1'b1;
            end
         end

         S_WR1: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = v_ff;
            if (hk_ff == h_ff) begin
               mem_wr_data.valid = 1'b1;
               mem_wr_data.key   = key_ff;
            end else begin
               // move displaced key with its link
               mem_wr_data       = eh_ff;
               mem_wr_data.valid = 1'b1;
            end
            state_in = S_WR2;
         end

         S_WR2: begin
            mem_wr_en = 1'b1;
            if (hk_ff == h_ff) begin
               // chain end links to the new slot
               mem_wr_addr = e_ff;
               if (v_ff == e_ff) begin
                  mem_wr_data.valid = 1'b1;
                  mem_wr_data.key   = key_ff;
               end else begin
                  mem_wr_data.valid = ee_ff.valid;
                  mem_wr_data.key   = ee_ff.key;
               end
               mem_wr_data.lpres = 1'b1;
               mem_wr_data.link  = v_ff;
               used_in           = used_ff + 1'b1;
               res_st_in         = ST_INSERTED;
               res_slot_in       = SLOT_W'(v_ff);
               state_in          = S_DONE;
            end else begin
               mem_wr_addr       = h_ff;
               mem_wr_data.valid = 1'b1;
               mem_wr_data.link  = eh_ff.link;
               mem_wr_data.key   = key_ff;
               if (havep_ff) begin
                  state_in = S_WR3;
               end else begin
                  used_in     = used_ff + 1'b1;
                  res_st_in   = ST_INSERTED;
                  res_slot_in = SLOT_W'(h_ff);
                  state_in    = S_DONE;
               end
            end
         end

         S_WR3: begin
            // relink predecessor; take the fresh contents if it was just rewritten
            mem_wr_en   = 1'b1;
            mem_wr_addr = cur_ff;
            if (cur_ff == h_ff) begin
               mem_wr_data.valid = 1'b1;
               mem_wr_data.key   = key_ff;
            end else if (cur_ff == v_ff) begin
               mem_wr_data       = eh_ff;
               mem_wr_data.valid = 1'b1;
            end else begin
               mem_wr_data = ee_ff;
            end
            mem_wr_data.link = v_ff;
            used_in          = used_ff + 1'b1;
            res_st_in        = ST_INSERTED;
            res_slot_in      = SLOT_W'(h_ff);
            state_in         = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: holds until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_st_in    = rsp_st_ff;
      rsp_slot_in  = rsp_slot_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_st_in    = res_st_ff;
         rsp_slot_in  = res_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cur_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      h_ff        <= h_in;
      hk_ff       <= hk_in;
      n_ff        <= n_in;
      e_ff        <= e_in;
      v_ff        <= v_in;
      havep_ff    <= havep_in;
      eh_ff       <= eh_in;
      ee_ff       <= ee_in;
      res_st_ff   <= res_st_in;
      res_slot_ff <= res_slot_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_st_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

// ===== test/hcwr_checker.sv =====
// Checker for the chained hash table: watches both channels, predicts each result.
// Depends on hcwr_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 100ps
module hcwr_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_mode,
   input  logic [hcwr_pkg::KEY_PORT_W-1:0] req_key,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [hcwr_pkg::STATUS_W-1:0] rsp_status,
   input  logic [hcwr_pkg::SLOT_W-1:0]   rsp_slot,
   output int                            fail_count,
   output int                            pending,
   output int                            rsp_seen
);
   import hcwr_pkg::*;
   localparam int NS = DEF_TABLE_SIZE;

   typedef struct packed {
      status_type   status;
      logic [3:0]   slot;
   } outcome_type;

   logic [15:0] keys [NS];
   logic        occ [NS];
   logic [3:0]  nxt [NS];
   logic        has_nxt [NS];
   int          fill;
   outcome_type outcomes_due[$];

   function automatic logic [3:0] home(logic [15:0] k);
      return k[3:0];
   endfunction

   function automatic bit vacancy(int start, output logic [3:0] v);
      int s;
      s = start % NS;
      for (int n = 0; n < NS; n++) begin
         if (!occ[s]) begin
            v = 4'(s);
            return 1;
         end
         s = (s + 1) % NS;
      end
      return 0;
   endfunction

   function automatic outcome_type table_insert(logic [15:0] k);
      outcome_type r;
      logic [3:0] h, e, v, p;
      bit pred;
      r.status = ST_FULL;
      r.slot = 0;
      pred = 0;
      h = home(k);
      if (fill >= NS) return r;
      if (!occ[h]) begin
         keys[h] = k; occ[h] = 1; has_nxt[h] = 0; r.slot = h;
      end else if (home(keys[h]) == h) begin
         e = h;
         for (int n = 0; n < NS && has_nxt[e]; n++) e = nxt[e];
         if (!vacancy(e, v)) return r;
         keys[v] = k; occ[v] = 1; has_nxt[v] = 0;
         nxt[e] = v; has_nxt[e] = 1; r.slot = v;
      end else begin
         if (!vacancy(h + 1, v)) return r;
         p = home(keys[h]);
         for (int n = 0; n < NS; n++) begin
            if (!has_nxt[p]) break;
            if (nxt[p] == h) begin
               pred = 1;
               break;
            end
            p = nxt[p];
         end
         keys[v] = keys[h]; occ[v] = 1;
         has_nxt[v] = has_nxt[h]; nxt[v] = nxt[h];
         keys[h] = k; has_nxt[h] = 0;
         if (pred) nxt[p] = v;
         r.slot = h;
      end
      fill++;
      r.status = ST_INSERTED;
      return r;
   endfunction

   function automatic outcome_type table_lookup(logic [15:0] k);
      outcome_type r;
      logic [3:0] s;
      r.status = ST_NOT_FOUND;
      r.slot = 0;
      s = home(k);
      if (!occ[s] || home(keys[s]) != s) return r;
      for (int n = 0; n < NS; n++) begin
         if (occ[s] && keys[s] == k) begin
            r.status = ST_FOUND;
            r.slot = s;
            return r;
         end
         if (!has_nxt[s]) return r;
         s = nxt[s];
      end
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   assign pending = outcomes_due.size();

   initial begin
      fail_count = 0;
      rsp_seen = 0;
   end

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         fill = 0;
         outcomes_due.delete();
         for (int i = 0; i < NS; i++) begin
            occ[i] = 0;
            has_nxt[i] = 0;
         end
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (outcomes_due.size() == 0)
               report("unexpected result", rsp_status, -1);
            else begin
               want = outcomes_due.pop_front();
               if (rsp_status !== want.status) report("status", rsp_status, want.status);
               if (rsp_slot !== want.slot) report("slot", rsp_slot, want.slot);
            end
         end
         if (req_valid && !req_stall)
            outcomes_due.push_back(req_mode ? table_lookup(req_key) : table_insert(req_key));
      end
   end
endmodule

// ===== test/tb_hash_table_chaining_with_replacement.sv =====
// Testbench top for the chained hash table: stimulus, stall patterns, verdict.
// Depends on hcwr_pkg, hcwr_checker and the block under test.
`timescale 1ns / 100ps
module tb_hash_table_chaining_with_replacement;
   import hcwr_pkg::*;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;
   localparam int   CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_mode = 0;
   logic [15:0] req_key = 0;
   logic        rsp_stall = 0;
   logic        req_stall, rsp_valid;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_slot;
   int          fail_count, pending, rsp_seen;
   int          cycles = 0;
   int          sent = 0;
   logic [15:0] recent_keys[$];

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   hash_table_chaining_with_replacement dut (.*);

   hcwr_checker chk (.*);

   // run guard: a stuck handshake ends the run as a failure
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, pending);
         $display("hash_table_chaining_with_replacement regression: fail");
         $finish;
      end
   end

   // receiver stall pattern: phases of no stall, light, and heavy stall
   always @(posedge clock) begin
      int ph;
      ph = (cycles / 700) % 3;
      if (ph == 0) rsp_stall <= 0;
      else if (ph == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= ($urandom_range(0, 3) != 0);
   end

   // one transfer on req_; valid holds until accepted
   task automatic push_item(logic mode, logic [15:0] key);
      req_valid <= 1;
      req_mode  <= mode;
      req_key   <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (!mode) begin
         recent_keys.push_back(key);
         if (recent_keys.size() > 32) void'(recent_keys.pop_front());
      end
   endtask

   task automatic pause_sender(int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   // random key biased to few homes so chains and displacement happen often
   function automatic logic [15:0] pick_key(int homes_mask);
      logic [15:0] k;
      k = 16'($urandom);
      case ($urandom_range(0, 3))
         0: k[3:0] = 4'($urandom_range(0, 15));
         default: k[3:0] = 4'($urandom & homes_mask);
      endcase
      return k;
   endfunction

   initial begin
      logic [15:0] k;
      int burst;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: empty lookups, extremes, same-home chain, displacement, fill
      push_item(OP_LOOKUP, 16'h0000);
      push_item(OP_INSERT, 16'h0000);
      push_item(OP_INSERT, 16'hFFFF);
      push_item(OP_INSERT, 16'h0010);      // same home as 0: chains onward
      push_item(OP_INSERT, 16'h0001);      // home 1 holds a displaced key
      push_item(OP_INSERT, 16'h0001);      // duplicate
      push_item(OP_LOOKUP, 16'h0010);
      push_item(OP_LOOKUP, 16'h0001);
      push_item(OP_LOOKUP, 16'hFFFF);
      push_item(OP_LOOKUP, 16'h0020);      // chain walked, missing
      push_item(OP_LOOKUP, 16'h0002);      // home holds displaced key
      for (int i = 0; i < 12; i++) push_item(OP_INSERT, 16'(16'h1230 + i * 16));
      push_item(OP_INSERT, 16'h5555);      // table full
      push_item(OP_LOOKUP, 16'(16'h1230 + 11 * 16));
      pause_sender(1);
      while (pending != 0) @(posedge clock);

      // random: fill/lookup rounds; only a reset empties the table, so later
      // inserts all see a full table, mixed with chained lookups
      while (sent < 650) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst; i++) begin
            if (recent_keys.size() != 0 && $urandom_range(0, 2) == 0)
               k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            else
               k = pick_key($urandom_range(0, 1) ? 16'h3 : 16'hF);
            push_item($urandom_range(0, 1) ? OP_LOOKUP : OP_INSERT, k);
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
      end
      req_valid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d requests and %0d results with chains, displacement,", sent,
               rsp_seen);
      $display("duplicates, full table and missing-key lookups under random stalls");
      if (fail_count == 0)
         $display("hash_table_chaining_with_replacement regression: pass");
      else
         $display("hash_table_chaining_with_replacement regression: fail");
      $finish;
   end
endmodule
